>>> rtl/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// shared types and constants of the flow statistics table
// ----------------------------------------------------------------------------
package fst_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int SLOTS = 2 * TABLE_ENTRIES;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int POS_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
	localparam logic [15:0] IPV6_MIN_BYTES = 16'd54;

	typedef enum logic [1:0] {
		STATUS_SKIP = 2'd0,
		STATUS_HIT = 2'd1,
		STATUS_NEW = 2'd2,
		STATUS_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] iface;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic is_ipv6;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [63:0] pkts;
		logic [63:0] bytes;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic step;
		logic wr_hit;
		logic wr_new;
		logic emit;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic at_end;
		logic full;
		logic match;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/flow_stats_table.sv
// ----------------------------------------------------------------------------
// flow_stats_table
// per-flow packet and byte counters for ingress and egress tables
// ----------------------------------------------------------------------------
// a skipped packet goes from load straight to the result register; an insert
// or a full table first reads and compares every filled entry, a hit stops at
// the matching entry (up to 1024 per table); all may wait for the result register
// throughput: one transaction at a time; the entry memory port, read then
// compare once per entry, sets the search time
// reset clears the fill counts at once, so no clearing pass is needed
module flow_stats_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input logic [15:0] if_index,
	input logic [15:0] ether_type,
	input logic [15:0] frame_length,
	input logic [63:0] src_addr_hi,
	input logic [63:0] src_addr_lo,
	input logic [63:0] dst_addr_hi,
	input logic [63:0] dst_addr_lo,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [10:0] slot,
	output logic [63:0] packet_count,
	output logic [63:0] byte_count
);
	import fst_pkg::*;

	cmd_t cmd;
	stat_t st;

	fst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.st(st), .cmd(cmd)
	);

	fst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.mode(mode), .if_index(if_index), .ether_type(ether_type),
		.frame_length(frame_length), .src_addr_hi(src_addr_hi),
		.src_addr_lo(src_addr_lo), .dst_addr_hi(dst_addr_hi),
		.dst_addr_lo(dst_addr_lo), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .slot(slot), .packet_count(packet_count),
		.byte_count(byte_count)
	);
endmodule

>>> rtl/fst_ctrl.sv
// ----------------------------------------------------------------------------
// fst_ctrl
// sequencer: classify, scan the filled part of the table, update or insert
// ----------------------------------------------------------------------------
module fst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fst_pkg::stat_t st,
	output fst_pkg::cmd_t cmd
);
	import fst_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_CMP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.code = STATUS_SKIP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (st.skip || st.at_end) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						if (st.skip) cmd.code = STATUS_SKIP;
						else if (st.full) cmd.code = STATUS_FULL;
						else begin
							cmd.code = STATUS_NEW;
							cmd.wr_new = 1'b1;
						end
						state_d = S_IDLE;
					end
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (st.match) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.wr_hit = 1'b1;
						cmd.code = STATUS_HIT;
						state_d = S_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d = S_LOOK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> rtl/fst_datapath.sv
// ----------------------------------------------------------------------------
// fst_datapath
// packet registers, fill counts, entry memory and result register
// ----------------------------------------------------------------------------
module fst_datapath (
	input logic clk,
	input logic arst_n,
	input fst_pkg::cmd_t cmd,
	output fst_pkg::stat_t st,
	input logic mode,
	input logic [15:0] if_index,
	input logic [15:0] ether_type,
	input logic [15:0] frame_length,
	input logic [63:0] src_addr_hi,
	input logic [63:0] src_addr_lo,
	input logic [63:0] dst_addr_hi,
	input logic [63:0] dst_addr_lo,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [10:0] slot,
	output logic [63:0] packet_count,
	output logic [63:0] byte_count
);
	import fst_pkg::*;

	logic mode_q;
	logic [15:0] iface_q, etype_q, len_q;
	logic [63:0] sh_q, sl_q, dh_q, dl_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] fill_q [2];
	entry_t mem [SLOTS];
	entry_t rd_q, wdata;
	logic v6;
	logic [63:0] sh, sl, dh, dl, kh, kl;
	logic [IDX_W-1:0] idx;
	logic [63:0] pk_d, by_d;
	logic out_valid_q;

	// ipv4 addresses keep only the first four bytes
	assign v6 = (etype_q == ETYPE_IPV6);
	assign sh = v6 ? sh_q : {sh_q[63:32], 32'd0};
	assign sl = v6 ? sl_q : 64'd0;
	assign dh = v6 ? dh_q : {dh_q[63:32], 32'd0};
	assign dl = v6 ? dl_q : 64'd0;
	assign kh = mode_q ? sh : dh;
	assign kl = mode_q ? sl : dl;
	assign idx = IDX_W'(mode_q) * IDX_W'(TABLE_ENTRIES) + IDX_W'(pos_q);

	always_comb begin
		st.skip = (len_q < ETH_HDR_BYTES) ||
			((etype_q == ETYPE_IPV4) ? (len_q < IPV4_MIN_BYTES) :
			(etype_q == ETYPE_IPV6) ? (len_q < IPV6_MIN_BYTES) : 1'b1);
		st.at_end = (pos_q == fill_q[mode_q]);
		st.full = (fill_q[mode_q] == POS_W'(TABLE_ENTRIES));
		st.match = (rd_q.iface == iface_q) && (rd_q.key_hi == kh) && (rd_q.key_lo == kl);
		st.out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		wdata = rd_q;
		pk_d = 64'd1;
		by_d = {48'd0, len_q};
		if (cmd.wr_hit) begin
			pk_d = rd_q.pkts + 64'd1;
			by_d = rd_q.bytes + {48'd0, len_q};
			if (v6) begin
				wdata.src_hi = sh;
				wdata.src_lo = sl;
				wdata.dst_hi = dh;
				wdata.dst_lo = dl;
			end else begin
				wdata.src_hi = {sh[63:32], rd_q.src_hi[31:0]};
				wdata.dst_hi = {dh[63:32], rd_q.dst_hi[31:0]};
			end
		end else begin
			wdata.iface = iface_q;
			wdata.key_hi = kh;
			wdata.key_lo = kl;
			wdata.is_ipv6 = v6;
			wdata.src_hi = sh;
			wdata.src_lo = sl;
			wdata.dst_hi = dh;
			wdata.dst_lo = dl;
		end
		wdata.pkts = pk_d;
		wdata.bytes = by_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			iface_q <= if_index;
			etype_q <= ether_type;
			len_q <= frame_length;
			sh_q <= src_addr_hi;
			sl_q <= src_addr_lo;
			dh_q <= dst_addr_hi;
			dl_q <= dst_addr_lo;
		end
		if (cmd.rd) rd_q <= mem[idx];
		if (cmd.wr_hit || cmd.wr_new) mem[idx] <= wdata;
		if (cmd.emit) begin
			status <= cmd.code;
			if (cmd.wr_hit || cmd.wr_new) begin
				slot <= 11'(idx);
				packet_count <= pk_d;
				byte_count <= by_d;
			end else begin
				slot <= '0;
				packet_count <= '0;
				byte_count <= '0;
			end
		end
	end

	// entries fill from the bottom and are never removed, so a count marks validity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) pos_q <= '0;
			else if (cmd.step) pos_q <= pos_q + POS_W'(1);
			if (cmd.wr_new) fill_q[mode_q] <= fill_q[mode_q] + POS_W'(1);
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

>>> rtl/fst_checker.sv
// ----------------------------------------------------------------------------
// fst_checker
// port-level checks on the flow statistics table
// ----------------------------------------------------------------------------
module fst_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] status,
	input logic [10:0] slot,
	input logic [63:0] packet_count,
	input logic [63:0] byte_count
);
	import fst_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot) &&
		$stable(packet_count) && $stable(byte_count))
		else $error("result changed while stalled");

	// the block works on one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_SKIP || status == STATUS_FULL) |->
		slot == 11'd0 && packet_count == 64'd0 && byte_count == 64'd0)
		else $error("skip or full result carries data");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_NEW |-> packet_count == 64'd1 &&
		byte_count >= 64'd34)
		else $error("new entry with bad totals");
endmodule

bind flow_stats_table fst_checker u_fst_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status), .slot(slot),
	.packet_count(packet_count), .byte_count(byte_count)
);
